// ===== rtl/bir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear resizer package
// Shared constants, register indices and the request context type.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int unsigned MaxSrcDimDef = 256;
  localparam int unsigned MaxDstDimDef = 1024;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 25;
  localparam int unsigned WeightW      = 12;
  localparam int unsigned WeightOne    = 2048;
  localparam int unsigned SumShift     = 22;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SCALE_X    = 3'd4,
    REG_SCALE_Y    = 3'd5,
    REG_COLOR_MODE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [WeightW-1:0] wx1;
    logic [WeightW-1:0] wy1;
    logic               beyond;
    logic               color;
  } req_ctx_t;

endpackage

// ===== rtl/bilinear_image_resizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image resizer
// Source frame store with half-pixel aligned bilinear lookup.
//
//   channel   direction  handshake           words
//   input     in         start_i / busy_o    load or request
//   result    out        done_o strobe       one per request
//   config    in         cfg_we_i            register write
//
// A load writes the frame store and does not raise busy_o. A request holds
// the input through the two mapping stages and until the last of the four
// neighbour reads from the frame store (one write and one read port). The
// result strobes with the finished sum. Requests overlap with the blend of
// the previous one. Reset clears control and configuration; the store holds
// undefined data until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bilinear_image_resizer #(
  parameter int unsigned MAX_DST_DIM = bir_pkg::MaxDstDimDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic [9:0]                    row_i,
  input  logic [9:0]                    col_i,
  input  logic [7:0]                    chan_a_i,
  input  logic [7:0]                    chan_b_i,
  input  logic [7:0]                    chan_c_i,
  output logic                          done_o,
  output logic [7:0]                    out_a_o,
  output logic [7:0]                    out_b_o,
  output logic [7:0]                    out_c_o,
  output logic                          beyond_o,
  input  logic                          cfg_we_i,
  input  logic [bir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bir_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bir_pkg::*;

  localparam int unsigned MAX_SRC_DIM = MaxSrcDimDef;
  localparam int unsigned SrcW   = $clog2(MAX_SRC_DIM);
  localparam int unsigned AddrW  = 2 * SrcW;
  localparam int unsigned Depth  = MAX_SRC_DIM * MAX_SRC_DIM;

  logic [8:0]  src_w_q, src_h_q;
  logic [10:0] dst_w_q, dst_h_q;
  logic [24:0] scale_x_q, scale_y_q;
  logic        color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= 9'd256;
      src_h_q   <= 9'd256;
      dst_w_q   <= 11'd256;
      dst_h_q   <= 11'd256;
      scale_x_q <= 25'd65536;
      scale_y_q <= 25'd65536;
      color_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SRC_WIDTH:  src_w_q   <= cfg_data_i[8:0];
        REG_SRC_HEIGHT: src_h_q   <= cfg_data_i[8:0];
        REG_DST_WIDTH:  dst_w_q   <= cfg_data_i[10:0];
        REG_DST_HEIGHT: dst_h_q   <= cfg_data_i[10:0];
        REG_SCALE_X:    scale_x_q <= cfg_data_i;
        REG_SCALE_Y:    scale_y_q <= cfg_data_i;
        REG_COLOR_MODE: color_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [8:0] clamp_src(input logic [8:0] v);
    if (v < 9'd2) return 9'd2;
    if ({23'd0, v} > 32'(MAX_SRC_DIM)) return 9'(MAX_SRC_DIM);
    return v;
  endfunction

  // Stage 0: accepted request captured; mapping runs over two stages.
  logic        accept;
  logic        req_v_q, req_v2_q;
  logic        beyond_d;
  logic        beyond_q, beyond2_q;
  logic [9:0]  row_q, col_q;
  logic [SrcW-1:0]    bx, by;
  logic [WeightW-1:0] wx1, wy1;

  // Read sequencer.
  logic [1:0]  rd_cnt_q;
  logic        rd_act_q;
  logic [SrcW-1:0] x_q, y_q;
  req_ctx_t    ctx_q;

  assign busy_o = req_v_q | req_v2_q | (rd_act_q & (rd_cnt_q != 2'd3));
  assign accept = start_i & ~busy_o;

  assign beyond_d = ({1'b0, row_i} >= dst_h_q) || ({1'b0, col_i} >= dst_w_q) ||
                    (32'(row_i) >= 32'(MAX_DST_DIM)) || (32'(col_i) >= 32'(MAX_DST_DIM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q  <= 1'b0;
      req_v2_q <= 1'b0;
    end else begin
      req_v_q  <= accept & mode_i;
      req_v2_q <= req_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_i;
      col_q    <= col_i;
      beyond_q <= beyond_d;
    end
    beyond2_q <= beyond_q;
  end

  bir_axis_map #(.DstW(10), .SrcW(SrcW)) u_map_x (
    .clk_i     (clk_i),
    .coord_i   (col_q),
    .scale_i   (scale_x_q),
    .src_dim_i (clamp_src(src_w_q)),
    .base_o    (bx),
    .w1_o      (wx1)
  );

  bir_axis_map #(.DstW(10), .SrcW(SrcW)) u_map_y (
    .clk_i     (clk_i),
    .coord_i   (row_q),
    .scale_i   (scale_y_q),
    .src_dim_i (clamp_src(src_h_q)),
    .base_o    (by),
    .w1_o      (wy1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q <= 1'b0;
      rd_cnt_q <= '0;
    end else if (req_v2_q) begin
      rd_act_q <= 1'b1;
      rd_cnt_q <= '0;
    end else if (rd_act_q) begin
      rd_cnt_q <= rd_cnt_q + 2'd1;
      if (rd_cnt_q == 2'd3) rd_act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_v2_q) begin
      x_q        <= bx;
      y_q        <= by;
      ctx_q.wx1  <= wx1;
      ctx_q.wy1  <= wy1;
      ctx_q.beyond <= beyond2_q;
      ctx_q.color  <= color_q;
    end
  end

  // Frame store.
  logic [23:0]     mem_q [Depth];
  logic [23:0]     rdata_q;
  logic [AddrW-1:0] raddr;
  logic [SrcW-1:0] rx, ry;
  logic            load_ok;

  assign rx = x_q + SrcW'(rd_cnt_q[0]);
  assign ry = y_q + SrcW'(rd_cnt_q[1]);
  assign raddr = {ry, rx};
  assign load_ok = accept & ~mode_i & (32'(row_i) < 32'(MAX_SRC_DIM)) &
                   (32'(col_i) < 32'(MAX_SRC_DIM));

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem_q[{row_i[SrcW-1:0], col_i[SrcW-1:0]}] <= {chan_c_i, chan_b_i, chan_a_i};
    end
    rdata_q <= mem_q[raddr];
  end

  // Weight for the neighbour whose read data is in rdata_q.
  logic [1:0]  ph_q;
  logic        ph_v_q;
  logic [WeightW-1:0] wx_sel, wy_sel;
  logic [22:0] w_prod_q;
  logic [1:0]  ph2_q;
  logic        ph2_v_q;

  always_comb begin
    wx_sel = ph_q[0] ? ctx_q.wx1 : WeightW'(WeightOne) - ctx_q.wx1;
    wy_sel = ph_q[1] ? ctx_q.wy1 : WeightW'(WeightOne) - ctx_q.wy1;
  end

  logic [23:0] pix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_v_q  <= 1'b0;
      ph2_v_q <= 1'b0;
    end else begin
      ph_v_q  <= rd_act_q;
      ph2_v_q <= ph_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q     <= rd_cnt_q;
    ph2_q    <= ph_q;
    w_prod_q <= 23'(wx_sel) * 23'(wy_sel);
    pix_q    <= rdata_q;
  end

  logic [7:0] res_a, res_b, res_c;

  bir_blend u_blend (
    .clk_i    (clk_i),
    .first_i  (ph2_q == 2'd0),
    .en_i     (ph2_v_q),
    .pix_i    (pix_q),
    .weight_i (w_prod_q),
    .res_a_o  (res_a),
    .res_b_o  (res_b),
    .res_c_o  (res_c)
  );

  // Context is registered with the last neighbour's weight; a new request
  // rewrites ctx_q only after its two mapping stages, so it is still intact.
  logic done_d;
  assign done_d = ph2_v_q & (ph2_q == 2'd3);
  logic done_q;
  logic beyond_r, color_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_v_q && ph_q == 2'd3) begin
      beyond_r <= ctx_q.beyond;
      color_r  <= ctx_q.color;
    end
  end

  assign done_o   = done_q;
  assign beyond_o = beyond_r;
  assign out_a_o  = beyond_r ? 8'd0 : res_a;
  assign out_b_o  = (beyond_r | ~color_r) ? 8'd0 : res_b;
  assign out_c_o  = (beyond_r | ~color_r) ? 8'd0 : res_c;

endmodule

// ===== rtl/bir_axis_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis mapper
// Maps a destination coordinate to a source base index and a 12-bit far
// weight with half-pixel alignment, with one register stage after the product.
// ----------------------------------------------------------------------------
module bir_axis_map #(
  parameter int unsigned DstW = 10,
  parameter int unsigned SrcW = 8
) (
  input  logic                         clk_i,
  input  logic [DstW-1:0]              coord_i,
  input  logic [24:0]                  scale_i,
  input  logic [8:0]                   src_dim_i,
  output logic [SrcW-1:0]              base_o,
  output logic [bir_pkg::WeightW-1:0]  w1_o
);
  import bir_pkg::*;

  localparam int unsigned ProdW = DstW + 1 + 25;

  logic [ProdW-1:0] prod_q, prod_d;
  logic [8:0]       dim_q;
  logic [ProdW-1:0] p;
  logic             neg;
  logic [ProdW-1:0] idx;
  logic [16:0]      frac;
  logic [8:0]       last;

  always_comb begin
    prod_d = ProdW'({coord_i, 1'b1}) * ProdW'(scale_i);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dim_q  <= src_dim_i;
  end

  always_comb begin
    neg  = prod_q < ProdW'(65536);
    p    = prod_q - ProdW'(65536);
    idx  = p >> 17;
    frac = p[16:0];
    last = dim_q - 9'd2;
    if (neg) begin
      base_o = '0;
      w1_o   = '0;
    end else if (idx > ProdW'(last)) begin
      base_o = last[SrcW-1:0];
      w1_o   = WeightW'(WeightOne);
    end else begin
      base_o = idx[SrcW-1:0];
      w1_o   = WeightW'((18'(frac) + 18'd63) >> 6);
    end
  end

endmodule

// ===== rtl/bir_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blend unit
// Accumulates four weighted neighbours per channel, one neighbour a cycle while en_i is high.
// ----------------------------------------------------------------------------
module bir_blend (
  input  logic                        clk_i,
  input  logic                        first_i,
  input  logic                        en_i,
  input  logic [23:0]                 pix_i,
  input  logic [22:0]                 weight_i,
  output logic [7:0]                  res_a_o,
  output logic [7:0]                  res_b_o,
  output logic [7:0]                  res_c_o
);
  import bir_pkg::*;

  logic [29:0] acc_q [3];
  logic [29:0] acc_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_d[k] = (first_i ? 30'd0 : acc_q[k]) + 30'(pix_i[8*k +: 8]) * 30'(weight_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) acc_q[k] <= acc_d[k];
    end
  end

  assign res_a_o = acc_q[0][SumShift +: 8];
  assign res_b_o = acc_q[1][SumShift +: 8];
  assign res_c_o = acc_q[2][SumShift +: 8];

endmodule

// ===== rtl/bir_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the resizer ports for result strobe width, beyond words and busy on requests and loads.
// ----------------------------------------------------------------------------
module bir_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       mode_i,
  input logic       done_o,
  input logic [7:0] out_a_o,
  input logic [7:0] out_b_o,
  input logic [7:0] out_c_o,
  input logic       beyond_o
);

  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && beyond_o |-> out_a_o == 8'd0 && out_b_o == 8'd0 && out_c_o == 8'd0)
    else $error("beyond word carries channel data");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i |=> busy_o)
    else $error("request did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !mode_i && !busy_o |=> !busy_o || $past(busy_o))
    else $error("load stalled the port");

endmodule

bind bilinear_image_resizer bir_checker u_bir_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .mode_i   (mode_i),
  .done_o   (done_o),
  .out_a_o  (out_a_o),
  .out_b_o  (out_b_o),
  .out_c_o  (out_c_o),
  .beyond_o (beyond_o)
);
